// ===== rtl/snp_pkg.sv =====
// Shared types and constants for the sensor packet parser.
package snp_pkg;

   // Header bytes 's', 'n', 'p'.
   localparam logic [7:0] HDR_S = 8'h73;
   localparam logic [7:0] HDR_N = 8'h6E;
   localparam logic [7:0] HDR_P = 8'h70;

   // Sum of the three header bytes, the starting value of the running sum.
   localparam logic [15:0] HDR_SUM = 16'(HDR_S) + 16'(HDR_N) + 16'(HDR_P);

   // Data bytes per register.
   localparam logic [5:0] BYTES_PER_REG = 6'd4;

   // Record kinds.
   localparam logic RK_DATA    = 1'b0;
   localparam logic RK_SUMMARY = 1'b1;

   typedef enum logic [2:0] {
      PH_HUNT,
      PH_N,
      PH_P,
      PH_TYPE,
      PH_ADDR,
      PH_DATA,
      PH_CSH,
      PH_CSL
   } phase_type;

   typedef struct packed {
      logic        record_kind;
      logic [7:0]  payload_byte;
      logic [5:0]  payload_index;
      logic [7:0]  packet_type;
      logic [7:0]  register_address;
      logic        has_payload;
      logic        batch_flag;
      logic [3:0]  batch_count;
      logic [15:0] computed_sum;
      logic [15:0] received_sum;
      logic        sum_matches;
   } rec_type;

endpackage

// ===== rtl/sensor_packet_parser_core.sv =====
// Sensor packet parser: header hunt, field decode, data records and checksum summary.
//
//   Channel | Direction | Handshake             | Payload
//   req_    | in        | req_valid / req_stall | rx_byte
//   rsp_    | out       | rsp_valid / rsp_stall | one data or summary record
//
// One byte is accepted per cycle while req_stall is low. A record that a byte produces
// is registered in the result register, or in the skid register if that one is held.
// A two-entry output buffer (result register plus skid register) lets a byte be
// accepted while a record waits; req_stall rises only when both entries are full.
// Synchronous active-high reset returns the parser to the header hunt and empties
// the output buffer.
module sensor_packet_parser_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_record_kind,
   output logic [7:0]  rsp_payload_byte,
   output logic [5:0]  rsp_payload_index,
   output logic [7:0]  rsp_packet_type,
   output logic [7:0]  rsp_register_address,
   output logic        rsp_has_payload,
   output logic        rsp_batch_flag,
   output logic [3:0]  rsp_batch_count,
   output logic [15:0] rsp_computed_sum,
   output logic [15:0] rsp_received_sum,
   output logic        rsp_sum_matches
);
   import snp_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [7:0]  type_ff, type_in;
   logic [7:0]  addr_ff, addr_in;
   logic [5:0]  left_ff, left_in;
   logic [5:0]  pos_ff, pos_in;
   logic [15:0] sum_ff, sum_in;
   logic [7:0]  chk_ff, chk_in;

   logic        out_valid_ff, out_valid_in;
   rec_type     out_ff, out_in;
   logic        skid_valid_ff, skid_valid_in;
   rec_type     skid_ff, skid_in;

   logic        accept;
   logic        out_take;
   logic        res_valid;
   rec_type     res;
   logic [15:0] sum_plus;
   logic [5:0]  payload_len;
   logic [15:0] rx_sum;

   assign accept   = req_valid && !req_stall;
   assign out_take = out_valid_ff && !rsp_stall;
   assign sum_plus = sum_ff + {8'd0, req_rx_byte};
   assign rx_sum   = {chk_ff, req_rx_byte};

   // Payload length is decided from the type byte already held when the address arrives.
   always_comb begin
      if (type_ff[7]) begin
         if (type_ff[6]) begin
            payload_len = {type_ff[5:2], 2'b00};
         end else begin
            payload_len = BYTES_PER_REG;
         end
      end else begin
         payload_len = 6'd0;
      end
   end

   // Next state of the parser.
   always_comb begin
      phase_in = phase_ff;
      type_in  = type_ff;
      addr_in  = addr_ff;
      left_in  = left_ff;
      pos_in   = pos_ff;
      sum_in   = sum_ff;
      chk_in   = chk_ff;
      unique case (phase_ff)
         PH_HUNT: begin
            if (req_rx_byte == HDR_S) phase_in = PH_N;
         end
         PH_N: begin
            if (req_rx_byte == HDR_N) phase_in = PH_P;
            else if (req_rx_byte == HDR_S) phase_in = PH_N;
            else phase_in = PH_HUNT;
         end
         PH_P: begin
            if (req_rx_byte == HDR_P) begin
               sum_in   = HDR_SUM;
               phase_in = PH_TYPE;
            end else if (req_rx_byte == HDR_S) begin
               phase_in = PH_N;
            end else begin
               phase_in = PH_HUNT;
            end
         end
         PH_TYPE: begin
            type_in  = req_rx_byte;
            sum_in   = sum_plus;
            phase_in = PH_ADDR;
         end
         PH_ADDR: begin
            addr_in  = req_rx_byte;
            sum_in   = sum_plus;
            pos_in   = 6'd0;
            left_in  = payload_len;
            phase_in = (payload_len == 6'd0) ? PH_CSH : PH_DATA;
         end
         PH_DATA: begin
            sum_in  = sum_plus;
            pos_in  = pos_ff + 6'd1;
            left_in = left_ff - 6'd1;
            if (left_ff == 6'd1) phase_in = PH_CSH;
         end
         PH_CSH: begin
            chk_in   = req_rx_byte;
            phase_in = PH_CSL;
         end
         PH_CSL: begin
            phase_in = PH_HUNT;
         end
         default: phase_in = PH_HUNT;
      endcase
   end

   // Record produced by the current byte, if any.
   always_comb begin
      res                  = '0;
      res.packet_type      = type_ff;
      res.register_address = addr_ff;
      res.has_payload      = type_ff[7];
      res.batch_flag       = type_ff[6];
      res.batch_count      = type_ff[5:2];
      res_valid            = 1'b0;
      unique case (phase_ff)
         PH_DATA: begin
            res_valid          = 1'b1;
            res.record_kind    = RK_DATA;
            res.payload_byte   = req_rx_byte;
            res.payload_index  = pos_ff;
            res.computed_sum   = sum_plus;
         end
         PH_CSL: begin
            res_valid          = 1'b1;
            res.record_kind    = RK_SUMMARY;
            res.computed_sum   = sum_ff;
            res.received_sum   = rx_sum;
            res.sum_matches    = (rx_sum == sum_ff);
         end
         default: res_valid = 1'b0;
      endcase
   end

   // Output buffer: the skid register catches a record when the result register is held.
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (out_take) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (accept && res_valid) begin
         if (!out_valid_ff || out_take) begin
            out_in       = res;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = res;
            skid_valid_in = 1'b1;
         end
      end else if (out_take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HUNT;
         type_ff       <= 8'd0;
         addr_ff       <= 8'd0;
         left_ff       <= 6'd0;
         pos_ff        <= 6'd0;
         sum_ff        <= 16'd0;
         chk_ff        <= 8'd0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff <= phase_in;
            type_ff  <= type_in;
            addr_ff  <= addr_in;
            left_ff  <= left_in;
            pos_ff   <= pos_in;
            sum_ff   <= sum_in;
            chk_ff   <= chk_in;
         end
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign req_stall            = skid_valid_ff;
   assign rsp_valid            = out_valid_ff;
   assign rsp_record_kind      = out_ff.record_kind;
   assign rsp_payload_byte     = out_ff.payload_byte;
   assign rsp_payload_index    = out_ff.payload_index;
   assign rsp_packet_type      = out_ff.packet_type;
   assign rsp_register_address = out_ff.register_address;
   assign rsp_has_payload      = out_ff.has_payload;
   assign rsp_batch_flag       = out_ff.batch_flag;
   assign rsp_batch_count      = out_ff.batch_count;
   assign rsp_computed_sum     = out_ff.computed_sum;
   assign rsp_received_sum     = out_ff.received_sum;
   assign rsp_sum_matches      = out_ff.sum_matches;

endmodule

// ===== rtl/snp_checker.sv =====
// Port-level checks for the sensor packet parser, bound to the top level.
module snp_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_record_kind,
   input logic [7:0]  rsp_payload_byte,
   input logic [5:0]  rsp_payload_index,
   input logic [7:0]  rsp_packet_type,
   input logic        rsp_has_payload,
   input logic        rsp_batch_flag,
   input logic [3:0]  rsp_batch_count,
   input logic [15:0] rsp_computed_sum,
   input logic [15:0] rsp_received_sum,
   input logic        rsp_sum_matches
);
   import snp_pkg::*;

   // A stalled record stays on the port.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_computed_sum))
      else $error("record dropped or changed while stalled");

   // The decoded flags always follow the type byte.
   a_type_decode: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_has_payload == rsp_packet_type[7] &&
                    rsp_batch_flag == rsp_packet_type[6] &&
                    rsp_batch_count == rsp_packet_type[5:2])
      else $error("decoded type fields disagree with the type byte");

   // Data records only come from packets that carry data, and stay inside 60 bytes.
   a_data_record: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_record_kind == RK_DATA |->
         rsp_has_payload && rsp_payload_index < 6'd60 &&
         rsp_received_sum == 16'd0 && !rsp_sum_matches)
      else $error("malformed data record");

   // The match flag of a summary reflects the two sums.
   a_summary_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_record_kind == RK_SUMMARY |->
         rsp_sum_matches == (rsp_computed_sum == rsp_received_sum) &&
         rsp_payload_byte == 8'd0 && rsp_payload_index == 6'd0)
      else $error("summary match flag is wrong");

endmodule

bind sensor_packet_parser_core snp_checker u_snp_checker (
   .clock                (clock),
   .reset                (reset),
   .rsp_valid            (rsp_valid),
   .rsp_stall            (rsp_stall),
   .rsp_record_kind      (rsp_record_kind),
   .rsp_payload_byte     (rsp_payload_byte),
   .rsp_payload_index    (rsp_payload_index),
   .rsp_packet_type      (rsp_packet_type),
   .rsp_has_payload      (rsp_has_payload),
   .rsp_batch_flag       (rsp_batch_flag),
   .rsp_batch_count      (rsp_batch_count),
   .rsp_computed_sum     (rsp_computed_sum),
   .rsp_received_sum     (rsp_received_sum),
   .rsp_sum_matches      (rsp_sum_matches)
);
